[src/mstw_pkg.sv]
// Shared types, constants and helpers for the multichannel sensor trip watchdog.
// Used by multichannel_sensor_trip_watchdog; depends on nothing else.
package mstw_pkg;

    localparam int NUM_CHANNELS = 19;
    localparam int CH_BITS      = 5;
    localparam int COUNT_BITS   = 16;
    localparam int NUM_GROUPS   = 5;
    localparam int GRP_BITS     = 3;
    localparam int RAW_BITS     = 16;
    localparam int FILT_BITS    = 24;
    localparam int LEVEL_BITS   = 24;
    localparam int FLIM_BITS    = 16;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    localparam logic [RAW_BITS-1:0]   RAW_HIGH_LIMIT = 16'd32000;
    localparam logic [CH_BITS-1:0]    LAST_CHANNEL   = 5'd18;
    localparam logic [CH_BITS-1:0]    FIRST_CHANNEL  = 5'd0;
    localparam logic [LEVEL_BITS-1:0] LEVEL_RESET    = 24'h80_0000;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEVEL_G0  = 3'd0,
        CFG_LEVEL_G1  = 3'd1,
        CFG_LEVEL_G2  = 3'd2,
        CFG_LEVEL_G3  = 3'd3,
        CFG_LEVEL_G4  = 3'd4,
        CFG_FAULT_G0  = 3'd5,
        CFG_FAULT_G14 = 3'd6
    } t_cfg_reg;

    // One channel entry of the state memory
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [FILT_BITS-1:0]  peak;
        logic [FILT_BITS-1:0]  hold_peak;
        logic [COUNT_BITS-1:0] hold_count;
    } t_chan_entry;

    // Map a channel to its limit group
    function automatic logic [GRP_BITS-1:0] group_of(input logic [CH_BITS-1:0] ch);
        logic [GRP_BITS-1:0] g;
        if (ch < 5'd3) begin
            g = 3'd0;
        end else if (ch < 5'd7) begin
            g = 3'd1;
        end else if (ch < 5'd11) begin
            g = 3'd2;
        end else if (ch < 5'd15) begin
            g = 3'd3;
        end else begin
            g = 3'd4;
        end
        return g;
    endfunction

endpackage

[src/multichannel_sensor_trip_watchdog.sv]
// Trip watchdog over 19 sensor channels with per-channel state in one memory.
// Depends on mstw_pkg for constants, the entry type and the group map.

// Takes one channel word per cycle while o_stall is low and returns its result
// via the stage-one and output registers. Per-channel counters, peaks and held
// values live in a 19-entry memory with one registered read port; a word reads
// its entry when accepted and, for a known channel unless tripped, writes it
// back on leaving stage one, with forwarding for the same channel on consecutive
// cycles. No clearing pass is needed: per-entry valid bits make unwritten
// entries read as zero right after reset. Status words, the trip flag and the
// limits are flip-flops. Limits are written through the configuration port,
// which is always ready and should be used while no words are in flight.
module multichannel_sensor_trip_watchdog (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [mstw_pkg::CH_BITS-1:0]       i_channel,
    input  logic signed [mstw_pkg::RAW_BITS-1:0]  i_raw_sample,
    input  logic signed [mstw_pkg::FILT_BITS-1:0] i_filtered_sample,
    input  logic                               i_period_end,
    // output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_trip,
    output logic [5:0]                         o_status_top,
    output logic [15:0]                        o_status_fault,
    output logic [15:0]                        o_status_level,
    output logic [mstw_pkg::FILT_BITS-1:0]     o_held_peak,
    output logic [mstw_pkg::COUNT_BITS-1:0]    o_held_fault_count,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mstw_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [mstw_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import mstw_pkg::*;

    // configuration registers
    logic [LEVEL_BITS-1:0]    r_level_limit [NUM_GROUPS];
    logic [FLIM_BITS-1:0]     r_fault_lim_g0;
    logic [CFG_DATA_BITS-1:0] r_fault_lim_g14;

    // state memory and entry valid bits
    t_chan_entry              mem [NUM_CHANNELS];
    t_chan_entry              r_mem_q;
    logic [NUM_CHANNELS-1:0]  r_vld;
    logic                     r_rd_vld;
    logic                     r_fwd_hit;
    t_chan_entry              r_fwd_data;

    // stage one
    logic                     r_s1_valid;
    logic [CH_BITS-1:0]       r_s1_ch;
    logic                     r_s1_chv;
    logic                     r_s1_fault;
    logic [FILT_BITS-1:0]     r_s1_filt_mag;
    logic                     r_s1_pend;

    // scalar watchdog state
    logic                     r_tripped;
    logic [5:0]               r_status_top;
    logic [15:0]              r_status_fault;
    logic [15:0]              r_status_level;

    // output register
    logic                     r_out_valid;
    logic                     r_out_trip;
    logic [5:0]               r_out_status_top;
    logic [15:0]              r_out_status_fault;
    logic [15:0]              r_out_status_level;
    logic [FILT_BITS-1:0]     r_out_held_peak;
    logic [COUNT_BITS-1:0]    r_out_held_count;

    // handshake and stage-zero signals
    logic                     out_ready;
    logic                     s1_move;
    logic                     accept;
    logic                     in_chv;
    logic [CH_BITS-1:0]       rd_idx;
    logic [RAW_BITS-1:0]      raw_mag;
    logic [FILT_BITS-1:0]     filt_mag;
    logic                     in_fault;

    // stage-one signals
    t_chan_entry              cur;
    t_chan_entry              n_entry;
    logic                     wr_en;
    logic [GRP_BITS-1:0]      grp;
    logic [COUNT_BITS-1:0]    cnt_new;
    logic [FILT_BITS-1:0]     peak_new;
    logic                     level_hit;
    logic                     fault_hit;
    logic [FLIM_BITS-1:0]     fault_lim;
    logic [NUM_CHANNELS-1:0]  ch_onehot;
    logic [NUM_CHANNELS-1:0]  lset;
    logic [NUM_CHANNELS-1:0]  fset;
    logic [5:0]               n_status_top;
    logic [15:0]              n_status_fault;
    logic [15:0]              n_status_level;
    logic                     n_tripped;
    logic [FILT_BITS-1:0]     n_held_peak;
    logic [COUNT_BITS-1:0]    n_held_count;

    // handshakes
    assign out_ready   = !r_out_valid || !i_stall;
    assign s1_move     = r_s1_valid && out_ready;
    assign o_stall     = r_s1_valid && !out_ready;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    // stage zero: magnitudes, fault test, read address
    always_comb begin
        in_chv   = (i_channel < CH_BITS'(NUM_CHANNELS));
        rd_idx   = in_chv ? i_channel : FIRST_CHANNEL;
        raw_mag  = i_raw_sample[RAW_BITS-1] ? (~i_raw_sample + 1'b1) : i_raw_sample;
        filt_mag = i_filtered_sample[FILT_BITS-1] ? (~i_filtered_sample + 1'b1)
                                                  : i_filtered_sample;
        in_fault = (raw_mag > RAW_HIGH_LIMIT) || (raw_mag == '0);
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                r_level_limit[g] <= LEVEL_RESET;
            end
            r_fault_lim_g0  <= '1;
            r_fault_lim_g14 <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_LEVEL_G0:  r_level_limit[0] <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_LEVEL_G1:  r_level_limit[1] <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_LEVEL_G2:  r_level_limit[2] <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_LEVEL_G3:  r_level_limit[3] <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_LEVEL_G4:  r_level_limit[4] <= i_cfg_data[LEVEL_BITS-1:0];
                CFG_FAULT_G0:  r_fault_lim_g0   <= i_cfg_data[FLIM_BITS-1:0];
                CFG_FAULT_G14: r_fault_lim_g14  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // memory: write back from stage one, registered read at accept
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_s1_ch] <= n_entry;
        end
        if (accept) begin
            r_mem_q <= mem[rd_idx];
        end
    end

    // entry valid bits and forward from the write in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_rd_vld  <= 1'b0;
            r_fwd_hit <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[r_s1_ch] <= 1'b1;
            end
            if (accept) begin
                r_rd_vld  <= r_vld[rd_idx];
                r_fwd_hit <= wr_en && (r_s1_ch == rd_idx);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fwd_data <= n_entry;
        end
    end

    // stage-one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_ch       <= i_channel;
            r_s1_chv      <= in_chv;
            r_s1_fault    <= in_fault;
            r_s1_filt_mag <= filt_mag;
            r_s1_pend     <= i_period_end;
        end
    end

    // stage one: modify the entry and the status words
    always_comb begin
        if (r_fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_rd_vld) begin
            cur = r_mem_q;
        end else begin
            cur = '0;
        end

        wr_en = s1_move && r_s1_chv && !r_tripped;
        grp   = group_of(r_s1_ch);

        case (grp)
            3'd0:    fault_lim = r_fault_lim_g0;
            3'd1:    fault_lim = r_fault_lim_g14[15:0];
            3'd2:    fault_lim = r_fault_lim_g14[31:16];
            3'd3:    fault_lim = r_fault_lim_g14[47:32];
            default: fault_lim = r_fault_lim_g14[63:48];
        endcase

        cnt_new = (r_s1_fault && (cur.count != {COUNT_BITS{1'b1}}))
                ? cur.count + 1'b1 : cur.count;
        peak_new  = (r_s1_filt_mag > cur.peak) ? r_s1_filt_mag : cur.peak;
        level_hit = r_s1_filt_mag > r_level_limit[grp];
        fault_hit = r_s1_pend && (cnt_new > COUNT_BITS'(fault_lim));

        n_entry.count      = cnt_new;
        n_entry.peak       = peak_new;
        n_entry.hold_peak  = cur.hold_peak;
        n_entry.hold_count = cur.hold_count;
        if (r_s1_pend) begin
            n_entry.hold_peak  = peak_new;
            n_entry.hold_count = cnt_new;
            n_entry.peak       = '0;
            n_entry.count      = '0;
        end

        ch_onehot = '0;
        if (r_s1_chv) begin
            ch_onehot[r_s1_ch] = 1'b1;
        end
        lset = level_hit ? ch_onehot : '0;
        fset = fault_hit ? ch_onehot : '0;

        // start of frame clears, then set this channel's bits
        if (r_s1_ch == FIRST_CHANNEL) begin
            n_status_top   = '0;
            n_status_fault = '0;
            n_status_level = '0;
        end else begin
            n_status_top   = r_status_top;
            n_status_fault = r_status_fault;
            n_status_level = r_status_level;
        end
        n_status_top   = n_status_top | {lset[2:0], fset[2:0]};
        n_status_fault = n_status_fault | fset[NUM_CHANNELS-1:3];
        n_status_level = n_status_level | lset[NUM_CHANNELS-1:3];
        n_tripped = (r_s1_ch == LAST_CHANNEL)
                  ? ((n_status_top != '0) || (n_status_fault != '0) || (n_status_level != '0))
                  : r_tripped;

        // held values shown with the result
        if (!r_s1_chv) begin
            n_held_peak  = '0;
            n_held_count = '0;
        end else if (r_tripped) begin
            n_held_peak  = cur.hold_peak;
            n_held_count = cur.hold_count;
        end else begin
            n_held_peak  = n_entry.hold_peak;
            n_held_count = n_entry.hold_count;
        end
    end

    // scalar state: frozen once tripped or for an unknown channel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tripped      <= 1'b0;
            r_status_top   <= '0;
            r_status_fault <= '0;
            r_status_level <= '0;
        end else if (wr_en) begin
            r_tripped      <= n_tripped;
            r_status_top   <= n_status_top;
            r_status_fault <= n_status_fault;
            r_status_level <= n_status_level;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out_trip         <= wr_en ? n_tripped      : r_tripped;
            r_out_status_top   <= wr_en ? n_status_top   : r_status_top;
            r_out_status_fault <= wr_en ? n_status_fault : r_status_fault;
            r_out_status_level <= wr_en ? n_status_level : r_status_level;
            r_out_held_peak    <= n_held_peak;
            r_out_held_count   <= n_held_count;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_trip             = r_out_trip;
    assign o_status_top       = r_out_status_top;
    assign o_status_fault     = r_out_status_fault;
    assign o_status_level     = r_out_status_level;
    assign o_held_peak        = r_out_held_peak;
    assign o_held_fault_count = r_out_held_count;

endmodule
